>>> hdl/bbea_pkg.sv
package bbea_pkg;

    localparam int ROW_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int RESET_WIDTH = 640;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 17;

    localparam logic [ROW_W-1:0] RESET_HEIGHT = 12'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // channel 2 = red, 1 = green, 0 = blue
    typedef logic [2:0][7:0] t_rgb;

    // row 0 = top, 1 = middle, 2 = bottom
    typedef t_rgb [2:0] t_col;

    typedef struct packed {
        t_rgb older;
        t_rgb newer;
    } t_pair;

    typedef struct packed {
        logic       cmd;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       end_of_row;
        logic       end_of_frame;
    } t_out_item;

    // 2^16 / count, rounded up; exact quotient for dividends below 4096
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] cnt);
        logic [RECIP_W-1:0] m;
        case (cnt)
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd6:    m = 17'd10923;
            4'd9:    m = 17'd7282;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage

>>> hdl/box_blur_3x3_edge_averaged_unit.sv
// 3x3 box blur of an RGB raster stream with edge-averaged borders. Each result is, per
// channel, the rounded-half-up mean of the in-frame pixels within one row and one column.
// Results lag the input by one row plus one pixel; after the last pixel of a frame, send
// drain requests (cmd = 1) to flush the rest, one result per drain. Both previous rows live
// in one MAX_WIDTH x 48 bit memory with one write port and two registered read ports; a
// 3-column window holds the neighborhood. The block takes one request per clock, and a
// result passes the s1, s2 and s3 registers into the output register; only a stalled,
// full output register stops intake. Row memory needs no clearing after reset. Write
// frame_width and frame_height only while the block is idle; a write restarts the frame.
module box_blur_3x3_edge_averaged_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  bbea_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output bbea_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bbea_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bbea_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bbea_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = CW + 1;
    localparam int RST_W = (RESET_WIDTH < MAX_WIDTH) ? RESET_WIDTH : MAX_WIDTH;

    typedef enum logic [2:0] {
        OP_PIX,
        OP_PIX_PRE,
        OP_PIX_POST,
        OP_DRN_WIN,
        OP_DRN_MEM
    } t_op;

    logic [WW-1:0]    r_eff_w;
    logic [ROW_W-1:0] r_eff_h;
    logic [CW-1:0]    r_in_col, n_in_col, r_out_col, n_out_col;
    logic [ROW_W-1:0] r_in_row, n_in_row, r_out_row, n_out_row;

    logic r_s1_valid, r_s1_res, r_s2_valid, r_s3_valid, r_out_valid;
    logic r_fwd_a, r_fwd_b;

    t_op              r_s1_op;
    t_rgb             r_s1_pix;
    logic [CW-1:0]    r_s1_addr;
    logic [2:0]       r_s1_colok, r_s1_rowok;
    logic [3:0]       r_s1_count;
    logic             r_s1_eor, r_s1_eof;

    t_pair            r_mem [MAX_WIDTH];
    t_pair            r_rd_a, r_rd_b, r_fwd_data;
    t_col             r_win [3];
    t_pair            r_left;

    logic [2:0][2:0][9:0] r_s2_colsum;
    logic [3:0]           r_s2_count;
    logic                 r_s2_eor, r_s2_eof;

    logic [2:0][11:0]     r_s3_tot;
    logic [3:0]           r_s3_count;
    logic                 r_s3_eor, r_s3_eof;

    t_out_item            r_out;

    logic             en, acc, go, res, emit, pix_ok, drn_ok, eor, eof, cfg_hit;
    t_op              op;
    logic [2:0]       colok, rowok;
    logic [1:0]       ncol, nrow;
    logic [3:0]       count;
    logic [WW-1:0]    oc1;
    logic [ROW_W:0]   or1;
    logic [CW-1:0]    rd_addr_a, rd_addr_b;
    logic             wr_en;
    t_pair            wr_data, m_a, m_b;
    t_col             colv;
    t_col             cells [3];
    logic [2:0][2:0][9:0] colsum;
    logic [2:0][11:0]     tot;
    logic [2:0][7:0]      quo;
    logic [28:0]          prod [3];

    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign acc         = i_in_valid && en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign cfg_hit     = i_cfg_valid &&
                         (i_cfg_index == CFG_FRAME_WIDTH || i_cfg_index == CFG_FRAME_HEIGHT);

    always_comb begin
        oc1    = {1'b0, r_out_col} + WW'(1);
        or1    = {1'b0, r_out_row} + 13'd1;
        pix_ok = (r_in_row < r_eff_h) && ({1'b0, r_in_col} < r_eff_w);
        drn_ok = (r_in_row >= r_eff_h) && (r_out_row < r_eff_h);
        emit   = (r_in_row >= 12'd2) || (r_in_row == 12'd1 && r_in_col != '0);
        go     = 1'b0;
        res    = 1'b0;
        op     = OP_PIX;
        if (i_in_data.cmd == CMD_DRAIN) begin
            if (drn_ok) begin
                go  = 1'b1;
                res = 1'b1;
                op  = (or1 < {1'b0, r_eff_h}) ? OP_DRN_WIN : OP_DRN_MEM;
            end
        end else if (pix_ok) begin
            go  = 1'b1;
            res = emit;
            if (!emit) begin
                op = OP_PIX;
            end else if (r_in_col != '0) begin
                op = OP_PIX_POST;
            end else begin
                op = OP_PIX_PRE;
            end
        end
        colok[0] = r_out_col != '0;
        colok[1] = 1'b1;
        colok[2] = (op == OP_PIX_POST || op == OP_DRN_MEM) && (oc1 < r_eff_w);
        rowok[0] = r_out_row != '0;
        rowok[1] = 1'b1;
        rowok[2] = (op != OP_DRN_MEM) && (or1 < {1'b0, r_eff_h});
        ncol     = 2'b01 + {1'b0, colok[0]} + {1'b0, colok[2]};
        nrow     = 2'b01 + {1'b0, rowok[0]} + {1'b0, rowok[2]};
        count    = {2'b00, ncol} * {2'b00, nrow};
        eor      = oc1 >= r_eff_w;
        eof      = eor && (or1 >= {1'b0, r_eff_h});
        rd_addr_a = (i_in_data.cmd == CMD_DRAIN) ? r_out_col : r_in_col;
        rd_addr_b = r_out_col + CW'(1);
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (acc && go) begin
            if (i_in_data.cmd == CMD_PIXEL) begin
                if (({1'b0, r_in_col} + WW'(1)) >= r_eff_w) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + 12'd1;
                end else begin
                    n_in_col = r_in_col + CW'(1);
                end
            end
            if (res) begin
                if (eor) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + 12'd1;
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
                if (eof) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end
            end
        end
        if (cfg_hit) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w     <= WW'(RST_W);
            r_eff_h     <= RESET_HEIGHT;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_res    <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_a     <= 1'b0;
            r_fwd_b     <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            if (i_cfg_valid && i_cfg_index == CFG_FRAME_WIDTH) begin
                if (i_cfg_data == '0) begin
                    r_eff_w <= WW'(1);
                end else if (32'(i_cfg_data) > 32'(MAX_WIDTH)) begin
                    r_eff_w <= WW'(MAX_WIDTH);
                end else begin
                    r_eff_w <= WW'(i_cfg_data);
                end
            end
            if (i_cfg_valid && i_cfg_index == CFG_FRAME_HEIGHT) begin
                r_eff_h <= (i_cfg_data == '0) ? 12'd1 : i_cfg_data;
            end
            if (en) begin
                r_s1_valid  <= acc && go;
                r_s1_res    <= acc && go && res;
                r_s2_valid  <= r_s1_valid && r_s1_res;
                r_s3_valid  <= r_s2_valid;
                r_out_valid <= r_s3_valid;
                r_fwd_a     <= wr_en && (r_s1_addr == rd_addr_a);
                r_fwd_b     <= wr_en && (r_s1_addr == rd_addr_b);
            end
        end
    end

    assign wr_en   = en && r_s1_valid &&
                     (r_s1_op == OP_PIX || r_s1_op == OP_PIX_PRE || r_s1_op == OP_PIX_POST);
    assign m_a     = r_fwd_a ? r_fwd_data : r_rd_a;
    assign m_b     = r_fwd_b ? r_fwd_data : r_rd_b;
    assign wr_data = '{older: m_a.newer, newer: r_s1_pix};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_s1_addr] <= wr_data;
        end
        if (en) begin
            r_rd_a <= r_mem[rd_addr_a];
            r_rd_b <= r_mem[rd_addr_b];
        end
    end

    always_comb begin
        colv = {r_s1_pix, m_a.newer, m_a.older};
        case (r_s1_op)
            OP_DRN_MEM: begin
                cells[0] = {t_rgb'('0), r_left.newer, r_left.older};
                cells[1] = {t_rgb'('0), m_a.newer, m_a.older};
                cells[2] = {t_rgb'('0), m_b.newer, m_b.older};
            end
            default: begin
                cells[0] = r_win[1];
                cells[1] = r_win[2];
                cells[2] = colv;
            end
        endcase
        for (int k = 0; k < 3; k++) begin
            for (int ch = 0; ch < 3; ch++) begin
                colsum[k][ch] = '0;
                for (int r = 0; r < 3; r++) begin
                    if (r_s1_colok[k] && r_s1_rowok[r]) begin
                        colsum[k][ch] = colsum[k][ch] + 10'(cells[k][r][ch]);
                    end
                end
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            tot[ch] = 12'(r_s2_colsum[0][ch]) + 12'(r_s2_colsum[1][ch])
                    + 12'(r_s2_colsum[2][ch]) + 12'(r_s2_count >> 1);
            prod[ch] = 29'(r_s3_tot[ch]) * 29'(recip(r_s3_count));
            quo[ch]  = prod[ch][RECIP_SHIFT +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_op    <= op;
            r_s1_pix   <= {i_in_data.red_in, i_in_data.green_in, i_in_data.blue_in};
            r_s1_addr  <= r_in_col;
            r_s1_colok <= colok;
            r_s1_rowok <= rowok;
            r_s1_count <= count;
            r_s1_eor   <= eor;
            r_s1_eof   <= eof;
            r_fwd_data <= wr_data;
            if (r_s1_valid && (r_s1_op == OP_PIX || r_s1_op == OP_PIX_PRE ||
                               r_s1_op == OP_PIX_POST)) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= colv;
            end
            if (r_s1_valid && r_s1_op == OP_DRN_MEM) begin
                r_left <= m_a;
            end
            r_s2_colsum <= colsum;
            r_s2_count  <= r_s1_count;
            r_s2_eor    <= r_s1_eor;
            r_s2_eof    <= r_s1_eof;
            r_s3_tot    <= tot;
            r_s3_count  <= r_s2_count;
            r_s3_eor    <= r_s2_eor;
            r_s3_eof    <= r_s2_eof;
            r_out.red_out      <= quo[2];
            r_out.green_out    <= quo[1];
            r_out.blue_out     <= quo[0];
            r_out.end_of_row   <= r_s3_eor;
            r_out.end_of_frame <= r_s3_eof;
        end
    end

endmodule

>>> hdl/bbea_monitor.sv
module bbea_monitor (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input bbea_pkg::t_in_item                i_in_data,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input bbea_pkg::t_out_item               o_out_data,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready,
    input logic [bbea_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input logic [bbea_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("request stalled without a stalled result");

    a_eof_on_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.end_of_frame |-> o_out_data.end_of_row)
        else $error("end of frame off a row end");

endmodule

bind box_blur_3x3_edge_averaged_unit bbea_monitor u_bbea_monitor (.*);
